// ===== rtl/core/umie_pkg.sv =====
`default_nettype none

package umie_pkg;

  localparam int DATA_W   = 32;
  localparam int NUM_REGS = 8;
  localparam int REG_AW   = 3;
  localparam int ACT_W    = 4;

  // opcodes, bits 31..28 of the instruction word
  localparam logic [3:0] OPC_CMOV   = 4'd0;
  localparam logic [3:0] OPC_LOAD   = 4'd1;
  localparam logic [3:0] OPC_STORE  = 4'd2;
  localparam logic [3:0] OPC_ADD    = 4'd3;
  localparam logic [3:0] OPC_MUL    = 4'd4;
  localparam logic [3:0] OPC_DIV    = 4'd5;
  localparam logic [3:0] OPC_NAND   = 4'd6;
  localparam logic [3:0] OPC_HALT   = 4'd7;
  localparam logic [3:0] OPC_MAP    = 4'd8;
  localparam logic [3:0] OPC_UNMAP  = 4'd9;
  localparam logic [3:0] OPC_OUTPUT = 4'd10;
  localparam logic [3:0] OPC_INPUT  = 4'd11;
  localparam logic [3:0] OPC_LOADP  = 4'd12;
  localparam logic [3:0] OPC_LOADI  = 4'd13;

  // result actions
  localparam logic [ACT_W-1:0] ACT_CONT     = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD     = 4'd1;
  localparam logic [ACT_W-1:0] ACT_STORE    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_MAP      = 4'd3;
  localparam logic [ACT_W-1:0] ACT_UNMAP    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_OUTPUT   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_INPUT    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_HALT     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_ILLEGAL  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_DIVFAULT = 4'd9;

  localparam logic [DATA_W-1:0] ALL_ONES  = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] CHAR_MASK = 32'h0000_00ff;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_LOAD  = 2'd1,
    WAIT_MAP   = 2'd2,
    WAIT_INPUT = 2'd3
  } wait_t;

  typedef enum logic [1:0] {
    FN_ADD  = 2'd0,
    FN_MUL  = 2'd1,
    FN_DIV  = 2'd2,
    FN_NAND = 2'd3
  } alu_fn_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_RD_BC = 3'd1,
    ST_RD_A  = 3'd2,
    ST_EXEC  = 3'd3,
    ST_ALU   = 3'd4,
    ST_EMIT  = 3'd5
  } state_t;

  typedef struct packed {
    logic    start;
    alu_fn_t fn;
  } alu_ctl_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/umie_regfile.sv =====
`default_nettype none

module umie_regfile
  import umie_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rf_wr_t            wr,
  input  wire logic [REG_AW-1:0] raddr0,
  input  wire logic [REG_AW-1:0] raddr1,
  output logic      [DATA_W-1:0] rdata0,
  output logic      [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0]   mem_r [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;
  logic [DATA_W-1:0]   rdata0_r;
  logic [DATA_W-1:0]   rdata1_r;

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rdata0_r <= valid_r[raddr0] ? mem_r[raddr0] : '0;
    rdata1_r <= valid_r[raddr1] ? mem_r[raddr1] : '0;
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

// ===== rtl/core/umie_alu.sv =====
`default_nettype none

module umie_alu
  import umie_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire alu_ctl_t          ctl,
  input  wire logic [DATA_W-1:0] opa,
  input  wire logic [DATA_W-1:0] opb,
  output logic                   done,
  output logic      [DATA_W-1:0] result
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] d_r;
  logic [DATA_W-1:0] res_r;

  logic [DATA_W:0]   rem_shift;
  logic [DATA_W+1:0] diff;
  logic              ge;
  logic [DATA_W-1:0] q_nxt;
  logic [DATA_W-1:0] rem_nxt;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_shift = {rem_r, q_r[DATA_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, d_r};
    ge        = ~diff[DATA_W+1];
    rem_nxt   = ge ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
    q_nxt     = {q_r[DATA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (ctl.start) begin
        if (ctl.fn == FN_DIV) begin
          busy_r <= 1'b1;
        end else begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        res_r <= q_nxt;
      end
    end else if (ctl.start) begin
      case (ctl.fn)
        FN_ADD:  res_r <= opa + opb;
        FN_MUL:  res_r <= opa * opb;
        FN_NAND: res_r <= ~(opa & opb);
        FN_DIV: begin
          q_r   <= opa;
          rem_r <= '0;
          d_r   <= opb;
          cnt_r <= CNT_W'(DATA_W - 1);
        end
        default: res_r <= '0;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/um_instruction_execute.sv =====
`default_nettype none

// channel | ports           | word layout
// --------+-----------------+-------------------------------------------------
// input   | in_t*  (slave)  | tuser[0] op; tdata instruction[31:0],
//         |                 |   reply_value[63:32], reply_eof[64]
// result  | out_t* (master) | tuser[3:0] action; tdata segment_id[31:0],
//         |                 |   word_offset[63:32], out_value[95:64],
//         |                 |   program_counter[127:96]
//
// One word at a time: accept, register file reads in ST_RD_BC and ST_RD_A,
// execute, emit; add, multiply, nand and divide also wait in ST_ALU, divide
// on the shared ALU's one-bit-a-cycle divider. Synchronous reset clears the
// state, program counter, pending reply, halt flag and output valid; the
// register file reads zero until written. A stalled result holds in the
// output register; the next word is still taken and processed, then waits in
// its emit state until that register is free.

module um_instruction_execute
  import umie_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,   // instruction, reply_value, reply_eof
  input  wire logic [0:0]   in_tuser,   // op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [127:0] out_tdata,  // segment_id, word_offset, out_value,
                                        // program_counter
  output logic      [3:0]   out_tuser   // action
);

  state_t state_r, state_nxt;

  logic              op_r, op_nxt;
  logic [DATA_W-1:0] instr_r, instr_nxt;
  logic [DATA_W-1:0] rv_r, rv_nxt;
  logic              eof_r, eof_nxt;
  logic [DATA_W-1:0] rb_r, rb_nxt;
  logic [DATA_W-1:0] rc_r, rc_nxt;

  logic [DATA_W-1:0] pc_r, pc_nxt;
  wait_t             pend_kind_r, pend_kind_nxt;
  logic [REG_AW-1:0] pend_reg_r, pend_reg_nxt;
  logic              stopped_r, stopped_nxt;

  logic [ACT_W-1:0]  res_act_r, res_act_nxt;
  logic [DATA_W-1:0] res_seg_r, res_seg_nxt;
  logic [DATA_W-1:0] res_off_r, res_off_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  logic [DATA_W-1:0] res_pc_r, res_pc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]  out_act_r, out_act_nxt;
  logic [DATA_W-1:0] out_seg_r, out_seg_nxt;
  logic [DATA_W-1:0] out_off_r, out_off_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [DATA_W-1:0] out_pc_r, out_pc_nxt;

  logic [3:0]        f_opc;
  logic [REG_AW-1:0] f_a, f_b, f_c, f_li;
  logic [DATA_W-1:0] pc_inc;

  rf_wr_t            rf_wr;
  logic [REG_AW-1:0] raddr0, raddr1;
  logic [DATA_W-1:0] rdata0, rdata1;
  alu_ctl_t          alu_ctl;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign f_opc  = instr_r[31:28];
  assign f_a    = instr_r[8:6];
  assign f_b    = instr_r[5:3];
  assign f_c    = instr_r[2:0];
  assign f_li   = instr_r[27:25];
  assign pc_inc = pc_r + 32'd1;

  assign raddr0 = (state_r == ST_RD_BC) ? f_b : f_a;
  assign raddr1 = f_c;

  umie_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (rf_wr),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  umie_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .opa    (rb_r),
    .opb    (rc_r),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    instr_nxt     = instr_r;
    rv_nxt        = rv_r;
    eof_nxt       = eof_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    pc_nxt        = pc_r;
    pend_kind_nxt = pend_kind_r;
    pend_reg_nxt  = pend_reg_r;
    stopped_nxt   = stopped_r;
    res_act_nxt   = res_act_r;
    res_seg_nxt   = res_seg_r;
    res_off_nxt   = res_off_r;
    res_val_nxt   = res_val_r;
    res_pc_nxt    = res_pc_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_act_nxt   = out_act_r;
    out_seg_nxt   = out_seg_r;
    out_off_nxt   = out_off_r;
    out_val_nxt   = out_val_r;
    out_pc_nxt    = out_pc_r;
    rf_wr         = '0;
    alu_ctl       = '0;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser[0];
          instr_nxt = in_tdata[31:0];
          rv_nxt    = in_tdata[63:32];
          eof_nxt   = in_tdata[64];
          state_nxt = ST_RD_BC;
        end
      end

      ST_RD_BC: state_nxt = ST_RD_A;

      ST_RD_A: begin
        rb_nxt    = rdata0;
        rc_nxt    = rdata1;
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        res_act_nxt = ACT_CONT;
        res_seg_nxt = '0;
        res_off_nxt = '0;
        res_val_nxt = '0;
        state_nxt   = ST_EMIT;
        if (stopped_r) begin
          res_act_nxt = ACT_HALT;
        end else if (op_r) begin
          rf_wr.addr = pend_reg_r;
          if (pend_kind_r == WAIT_LOAD || pend_kind_r == WAIT_MAP) begin
            rf_wr.en   = 1'b1;
            rf_wr.data = rv_r;
          end else if (pend_kind_r == WAIT_INPUT) begin
            rf_wr.en   = 1'b1;
            rf_wr.data = eof_r ? ALL_ONES : (rv_r & CHAR_MASK);
          end
          pend_kind_nxt = WAIT_NONE;
        end else if (pend_kind_r != WAIT_NONE) begin
          // instruction while a reply is outstanding: dropped
        end else begin
          case (f_opc)
            OPC_CMOV: begin
              rf_wr.en   = (rc_r != '0);
              rf_wr.addr = f_a;
              rf_wr.data = rb_r;
              pc_nxt     = pc_inc;
            end
            OPC_LOAD: begin
              pend_kind_nxt = WAIT_LOAD;
              pend_reg_nxt  = f_a;
              pc_nxt        = pc_inc;
              res_act_nxt   = ACT_LOAD;
              res_seg_nxt   = rb_r;
              res_off_nxt   = rc_r;
            end
            OPC_STORE: begin
              pc_nxt      = pc_inc;
              res_act_nxt = ACT_STORE;
              res_seg_nxt = rdata0;
              res_off_nxt = rb_r;
              res_val_nxt = rc_r;
            end
            OPC_ADD: begin
              alu_ctl.start = 1'b1;
              alu_ctl.fn    = FN_ADD;
              state_nxt     = ST_ALU;
            end
            OPC_MUL: begin
              alu_ctl.start = 1'b1;
              alu_ctl.fn    = FN_MUL;
              state_nxt     = ST_ALU;
            end
            OPC_DIV: begin
              if (rc_r == '0) begin
                stopped_nxt = 1'b1;
                res_act_nxt = ACT_DIVFAULT;
              end else begin
                alu_ctl.start = 1'b1;
                alu_ctl.fn    = FN_DIV;
                state_nxt     = ST_ALU;
              end
            end
            OPC_NAND: begin
              alu_ctl.start = 1'b1;
              alu_ctl.fn    = FN_NAND;
              state_nxt     = ST_ALU;
            end
            OPC_HALT: begin
              stopped_nxt = 1'b1;
              res_act_nxt = ACT_HALT;
            end
            OPC_MAP: begin
              pend_kind_nxt = WAIT_MAP;
              pend_reg_nxt  = f_b;
              pc_nxt        = pc_inc;
              res_act_nxt   = ACT_MAP;
              res_val_nxt   = rc_r;
            end
            OPC_UNMAP: begin
              pc_nxt      = pc_inc;
              res_act_nxt = ACT_UNMAP;
              res_seg_nxt = rc_r;
            end
            OPC_OUTPUT: begin
              pc_nxt      = pc_inc;
              res_act_nxt = ACT_OUTPUT;
              res_val_nxt = rc_r & CHAR_MASK;
            end
            OPC_INPUT: begin
              pend_kind_nxt = WAIT_INPUT;
              pend_reg_nxt  = f_c;
              pc_nxt        = pc_inc;
              res_act_nxt   = ACT_INPUT;
            end
            OPC_LOADP: pc_nxt = rc_r;
            OPC_LOADI: begin
              rf_wr.en   = 1'b1;
              rf_wr.addr = f_li;
              rf_wr.data = {7'd0, instr_r[24:0]};
              pc_nxt     = pc_inc;
            end
            default: begin
              stopped_nxt = 1'b1;
              res_act_nxt = ACT_ILLEGAL;
            end
          endcase
        end
        res_pc_nxt = (state_nxt == ST_ALU) ? pc_inc : pc_nxt;
      end

      ST_ALU: begin
        if (alu_done) begin
          rf_wr.en   = 1'b1;
          rf_wr.addr = f_a;
          rf_wr.data = alu_result;
          pc_nxt     = pc_inc;
          state_nxt  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = res_act_r;
          out_seg_nxt   = res_seg_r;
          out_off_nxt   = res_off_r;
          out_val_nxt   = res_val_r;
          out_pc_nxt    = res_pc_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      pend_kind_r <= WAIT_NONE;
      pend_reg_r  <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      pend_kind_r <= pend_kind_nxt;
      pend_reg_r  <= pend_reg_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    instr_r   <= instr_nxt;
    rv_r      <= rv_nxt;
    eof_r     <= eof_nxt;
    rb_r      <= rb_nxt;
    rc_r      <= rc_nxt;
    res_act_r <= res_act_nxt;
    res_seg_r <= res_seg_nxt;
    res_off_r <= res_off_nxt;
    res_val_r <= res_val_nxt;
    res_pc_r  <= res_pc_nxt;
    out_act_r <= out_act_nxt;
    out_seg_r <= out_seg_nxt;
    out_off_r <= out_off_nxt;
    out_val_r <= out_val_nxt;
    out_pc_r  <= out_pc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {out_pc_r, out_val_r, out_off_r, out_seg_r};

endmodule

`default_nettype wire
